[hdl/i2cms_pkg.sv]
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and codes for the two-wire bus master transaction sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_START = 2'd2,
    OP_EVENT = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    EV_START      = 4'd0,
    EV_REPSTART   = 4'd1,
    EV_TXADR_ACK  = 4'd2,
    EV_TXDATA_ACK = 4'd3,
    EV_RXDATA_ACK = 4'd4,
    EV_RXADR_ACK  = 4'd5,
    EV_RXDATA_NACK= 4'd6,
    EV_ARBLOST    = 4'd7,
    EV_TXADR_NACK = 4'd8,
    EV_RXADR_NACK = 4'd9,
    EV_TXDATA_NACK= 4'd10,
    EV_BUSERR     = 4'd11,
    EV_OTHER      = 4'd12
  } event_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_RX_ACK  = 3'd2,
    ACT_RX_NACK = 3'd3,
    ACT_STOP    = 3'd4,
    ACT_RESTART = 3'd5,
    ACT_HALT    = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_TXADR_NACK = 3'd1,
    ERR_RXADR_NACK = 3'd2,
    ERR_TXDATA_NACK= 3'd3,
    ERR_BUS        = 3'd4,
    ERR_UNEXPECTED = 3'd5
  } err_e;

  localparam int unsigned PtrW = 6;
  localparam logic [PtrW-1:0] PtrMax = '1;

  // Per-beat result from the control stage; data bytes are muxed from RAM q.
  typedef struct packed {
    action_e action;
    logic    sel_tx;
    logic    sel_rd;
    logic    busy;
    logic    ok;
    err_e    err;
  } res_t;

endpackage : i2cms_pkg

`default_nettype wire

[hdl/i2cms_ram.sv]
// ----------------------------------------------------------------------------
// i2cms_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule : i2cms_ram

`default_nettype wire

[hdl/i2cms_ctrl.sv]
// ----------------------------------------------------------------------------
// i2cms_ctrl
// Transfer state and per-beat decision logic; drives the buffer RAM port.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_ctrl
  import i2cms_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            accept_i,
  input  wire op_e                             op_i,
  input  wire logic [4:0]                      index_i,
  input  wire logic [7:0]                      data_i,
  input  wire logic [5:0]                      mlen_i,
  input  wire logic                            hold_i,
  input  wire logic [3:0]                      event_i,
  output logic                                 mem_en_o,
  output logic                                 mem_we_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0]      mem_addr_o,
  output logic [7:0]                           mem_wdata_o,
  output res_t                                 res_o
);

  localparam int unsigned AddrW = $clog2(BUFFER_DEPTH);

  logic [PtrW-1:0] len_q, len_d;
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic            hold_q, hold_d;
  logic            active_q, active_d;
  logic            ok_q, ok_d;
  err_e            err_q, err_d;

  logic            mem_en;
  logic            mem_we;
  logic [AddrW-1:0] mem_addr;
  action_e         action;
  logic            sel_tx, sel_rd;
  logic [PtrW-1:0] ptr_base, ptr_inc;
  logic            idx_ok, base_ok, ptr_ok;

  always_comb begin
    len_d    = len_q;
    ptr_d    = ptr_q;
    hold_d   = hold_q;
    active_d = active_q;
    ok_d     = ok_q;
    err_d    = err_q;
    mem_en   = 1'b0;
    mem_we   = 1'b0;
    mem_addr = AddrW'(index_i);
    action   = ACT_NONE;
    sel_tx   = 1'b0;
    sel_rd   = 1'b0;

    idx_ok   = int'(index_i) < BUFFER_DEPTH;
    ptr_ok   = int'(ptr_q) < BUFFER_DEPTH;
    ptr_base = ((event_i == EV_START) || (event_i == EV_REPSTART)) ? '0 : ptr_q;
    base_ok  = int'(ptr_base) < BUFFER_DEPTH;
    ptr_inc  = (ptr_q == PtrMax) ? ptr_q : ptr_q + 1'b1;

    case (op_i)
      OP_WRITE: begin
        mem_en = idx_ok;
        mem_we = 1'b1;
      end
      OP_READ: begin
        mem_en = idx_ok;
        sel_rd = idx_ok;
      end
      OP_START: begin
        if (!active_q) begin
          if (mlen_i != '0) begin
            len_d = (int'(mlen_i) > BUFFER_DEPTH) ? PtrW'(BUFFER_DEPTH) : mlen_i;
          end
          ok_d     = 1'b0;
          err_d    = ERR_NONE;
          hold_d   = hold_i;
          active_d = 1'b1;
          action   = ACT_RESTART;
        end
      end
      OP_EVENT: begin
        if (active_q) begin
          case (event_e'(event_i))
            EV_START, EV_REPSTART, EV_TXADR_ACK, EV_TXDATA_ACK: begin
              ptr_d = ptr_base;
              if (ptr_base < len_q) begin
                mem_en   = base_ok;
                mem_addr = AddrW'(ptr_base);
                sel_tx   = base_ok;
                ptr_d    = (ptr_base == PtrMax) ? ptr_base : ptr_base + 1'b1;
                action   = ACT_SEND;
              end else begin
                ok_d     = 1'b1;
                active_d = 1'b0;
                if (hold_q) begin
                  hold_d = 1'b0;
                end else begin
                  action = ACT_STOP;
                end
              end
            end
            EV_RXDATA_ACK: begin
              mem_en   = ptr_ok;
              mem_we   = 1'b1;
              mem_addr = AddrW'(ptr_q);
              ptr_d    = ptr_inc;
              action   = ({1'b0, ptr_inc} + 7'd1 < {1'b0, len_q}) ? ACT_RX_ACK : ACT_RX_NACK;
            end
            EV_RXADR_ACK: begin
              action = ({1'b0, ptr_q} + 7'd1 < {1'b0, len_q}) ? ACT_RX_ACK : ACT_RX_NACK;
            end
            EV_RXDATA_NACK: begin
              mem_en   = ptr_ok;
              mem_we   = 1'b1;
              mem_addr = AddrW'(ptr_q);
              ok_d     = 1'b1;
              active_d = 1'b0;
              action   = ACT_STOP;
            end
            EV_ARBLOST: begin
              action = ACT_RESTART;
            end
            EV_TXADR_NACK: begin
              err_d = ERR_TXADR_NACK; active_d = 1'b0; action = ACT_HALT;
            end
            EV_RXADR_NACK: begin
              err_d = ERR_RXADR_NACK; active_d = 1'b0; action = ACT_HALT;
            end
            EV_TXDATA_NACK: begin
              err_d = ERR_TXDATA_NACK; active_d = 1'b0; action = ACT_HALT;
            end
            EV_BUSERR: begin
              err_d = ERR_BUS; active_d = 1'b0; action = ACT_HALT;
            end
            default: begin
              // codes 12..15 all land here
              err_d = ERR_UNEXPECTED; active_d = 1'b0; action = ACT_HALT;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      ptr_q    <= '0;
      hold_q   <= 1'b0;
      active_q <= 1'b0;
      ok_q     <= 1'b0;
      err_q    <= ERR_NONE;
    end else if (accept_i) begin
      len_q    <= len_d;
      ptr_q    <= ptr_d;
      hold_q   <= hold_d;
      active_q <= active_d;
      ok_q     <= ok_d;
      err_q    <= err_d;
    end
  end

  assign mem_en_o    = accept_i & mem_en;
  assign mem_we_o    = mem_we;
  assign mem_addr_o  = mem_addr;
  assign mem_wdata_o = data_i;

  assign res_o.action = action;
  assign res_o.sel_tx = sel_tx;
  assign res_o.sel_rd = sel_rd;
  assign res_o.busy   = active_d;
  assign res_o.ok     = ok_d;
  assign res_o.err    = err_d;

`ifndef SYNTH
  // A latched error always means the transfer has ended.
  a_err_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ERR_NONE) |-> !active_q)
    else $error("error latched while transfer active");

  // Transfer state only moves on an accepted beat.
  a_active_on_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(active_q) || $fell(active_q)) |-> $past(accept_i))
    else $error("active changed without a beat");

  // An accepted start from idle opens a transfer with a clean status.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && op_i == OP_START && !active_q) |=> (active_q && !ok_q && err_q == ERR_NONE))
    else $error("start did not open a transfer");

  // A halt always ends the transfer with an error code latched.
  a_halt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && action == ACT_HALT) |-> (!active_d && err_d != ERR_NONE))
    else $error("halt without error");
`endif

endmodule : i2cms_ctrl

`default_nettype wire

[hdl/i2c_master_transaction_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Master-side two-wire bus sequencer: message buffer plus transfer control.
// ----------------------------------------------------------------------------
// Every input beat (buffer write, buffer read, start, or bus status event)
// yields exactly one result beat. The block takes one beat per clock while
// the output is not stalled: the decision is made in the accept cycle, the
// buffer RAM is read on the same edge, and the result comes out of a one-deep
// output register in the following cycle. Throughput is therefore one beat per
// cycle; the single RAM port does one read or write per beat.
// A stalled result holds the input side only until it is taken.
`default_nettype none

module i2c_master_transaction_sequencer
  import i2cms_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [4:0] index, [12:5] data, [18:13] message_length, [19] hold_bus, [23:20] bus_event
  input  wire logic [23:0] s_axis_tdata_i,
  // [1:0] operation
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] tx_byte, [15:8] read_data, [16] busy_res, [17] transfer_ok,
  // [20:18] error_code, [23:21] zero
  output logic [23:0]      m_axis_tdata_o,
  // [2:0] bus_action
  output logic [2:0]       m_axis_tuser_o
);

  localparam int unsigned AddrW = $clog2(BUFFER_DEPTH);

  logic             accept;
  logic             mem_en, mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [7:0]       mem_wdata, mem_rdata;
  res_t             res;
  res_t             res_q;
  logic             valid_q;

  assign s_axis_tready_o = !valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  i2cms_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .op_i       (op_e'(s_axis_tuser_i)),
    .index_i    (s_axis_tdata_i[4:0]),
    .data_i     (s_axis_tdata_i[12:5]),
    .mlen_i     (s_axis_tdata_i[18:13]),
    .hold_i     (s_axis_tdata_i[19]),
    .event_i    (s_axis_tdata_i[23:20]),
    .mem_en_o   (mem_en),
    .mem_we_o   (mem_we),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata),
    .res_o      (res)
  );

  i2cms_ram #(
    .Width(8),
    .Depth(BUFFER_DEPTH)
  ) u_buf (
    .clk_i  (clk_i),
    .en_i   (mem_en),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  // RAM q only moves on accept, so it stays aligned with res_q under stall.
  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tuser_o  = res_q.action;
  assign m_axis_tdata_o  = {3'b000, res_q.err, res_q.ok, res_q.busy,
                            res_q.sel_rd ? mem_rdata : 8'h00,
                            res_q.sel_tx ? mem_rdata : 8'h00};

endmodule : i2c_master_transaction_sequencer

`default_nettype wire
